@@ hdl/screen_and_motor_timed_sequencer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the screen and motor timed sequencer
// Each macro expands to a labeled concurrent assertion, or to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SCREEN_AND_MOTOR_TIMED_SEQUENCER_TOP_DEFINES_SVH
`define SCREEN_AND_MOTOR_TIMED_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTH
// Consequent checked on the same edge as the antecedent.
`define SMTS_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("smts: assertion failed");
// Consequent checked on the edge after the antecedent.
`define SMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("smts: assertion failed");
`else
`define SMTS_ASSERT(label, clk, rst_n, ante, cons)
`define SMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/smts_pkg.sv @@
// ----------------------------------------------------------------------------
// smts_pkg
// Types and constants shared by the screen and motor timed sequencer.
// ----------------------------------------------------------------------------
package smts_pkg;

	localparam int SETTING_W  = 9;
	localparam int TPU_W      = 10;
	localparam int CNT_W      = 19;
	localparam int TICK16_W   = 16;
	localparam int TICK8_W    = 8;
	localparam int PAGE_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_SET    = 4;

	localparam logic [SETTING_W-1:0] SETTING_MAX = SETTING_W'(300);

	localparam logic [PAGE_W-1:0] PAGE_RUN  = PAGE_W'(0);
	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(4);

	localparam logic [TPU_W-1:0]    RST_TICKS_PER_UNIT = TPU_W'(500);
	localparam logic [TICK16_W-1:0] RST_LEAD_TICKS     = TICK16_W'(1000);
	localparam logic [TICK16_W-1:0] RST_REPEAT_DELAY   = TICK16_W'(500);
	localparam logic [TICK8_W-1:0]  RST_REPEAT_PERIOD  = TICK8_W'(50);
	localparam logic [TICK16_W-1:0] RST_MENU_HOLD      = TICK16_W'(2000);
	localparam logic [TICK16_W-1:0] RST_MENU_TIMEOUT   = TICK16_W'(20000);
	localparam logic [TICK8_W-1:0]  RST_DEBOUNCE_TICKS = TICK8_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICKS_PER_UNIT,
		REG_LEAD_TICKS,
		REG_REPEAT_DELAY,
		REG_REPEAT_PERIOD,
		REG_MENU_HOLD,
		REG_MENU_TIMEOUT,
		REG_DEBOUNCE_TICKS
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_LOWER,
		MODE_RAISE
	} mode_t;

	typedef struct packed {
		logic [TPU_W-1:0]    ticks_per_unit;
		logic [TICK16_W-1:0] lead_ticks;
		logic [TICK16_W-1:0] repeat_delay;
		logic [TICK8_W-1:0]  repeat_period;
		logic [TICK16_W-1:0] menu_hold;
		logic [TICK16_W-1:0] menu_timeout;
		logic [TICK8_W-1:0]  debounce_ticks;
	} cfg_t;

	// Button bits: 0 up, 1 down, 2 menu.
	typedef struct packed {
		logic [2:0] stable;
		logic       accept;
		logic [2:0] level;
	} btn_t;

	typedef logic [NUM_SET-1:0][SETTING_W-1:0] setting_arr_t;

	typedef struct packed {
		logic         motor_down_on;
		logic         motor_up_on;
		logic         screen_down_on;
		logic         screen_up_on;
		logic [1:0]   run_mode;
		logic [PAGE_W-1:0] page;
		logic         save_pulse;
		setting_arr_t settings;
	} res_t;

endpackage

@@ hdl/smts_cfg.sv @@
// ----------------------------------------------------------------------------
// smts_cfg
// Configuration register file, written by index, with defaults at reset.
// ----------------------------------------------------------------------------
module smts_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [smts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smts_pkg::CFG_DATA_W-1:0]  cfg_data,
	output smts_pkg::cfg_t                   cfg
);
	import smts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_unit <= RST_TICKS_PER_UNIT;
			cfg_q.lead_ticks     <= RST_LEAD_TICKS;
			cfg_q.repeat_delay   <= RST_REPEAT_DELAY;
			cfg_q.repeat_period  <= RST_REPEAT_PERIOD;
			cfg_q.menu_hold      <= RST_MENU_HOLD;
			cfg_q.menu_timeout   <= RST_MENU_TIMEOUT;
			cfg_q.debounce_ticks <= RST_DEBOUNCE_TICKS;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_data[TPU_W-1:0];
				REG_LEAD_TICKS:     cfg_q.lead_ticks     <= cfg_data[TICK16_W-1:0];
				REG_REPEAT_DELAY:   cfg_q.repeat_delay   <= cfg_data[TICK16_W-1:0];
				REG_REPEAT_PERIOD:  cfg_q.repeat_period  <= cfg_data[TICK8_W-1:0];
				REG_MENU_HOLD:      cfg_q.menu_hold      <= cfg_data[TICK16_W-1:0];
				REG_MENU_TIMEOUT:   cfg_q.menu_timeout   <= cfg_data[TICK16_W-1:0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[TICK8_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/smts_debounce.sv @@
// ----------------------------------------------------------------------------
// smts_debounce
// Debounces the three raw button levels and flags when a level is accepted.
// ----------------------------------------------------------------------------
module smts_debounce (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [2:0]                        raw,
	input  logic [smts_pkg::TICK8_W-1:0]      debounce_ticks,
	output smts_pkg::btn_t                    btn
);
	import smts_pkg::*;

	logic [2:0]         cand_q;
	logic [2:0]         stable_q;
	logic [TICK8_W-1:0] left_q;
	logic [2:0]         n_cand;
	logic [2:0]         n_stable;
	logic [TICK8_W-1:0] n_left;
	logic               acc;

	always_comb begin
		n_cand = cand_q;
		n_left = left_q;
		acc    = 1'b0;
		if (raw != cand_q) begin
			n_cand = raw;
			n_left = debounce_ticks;
			acc    = (debounce_ticks == '0);
		end else if (left_q != '0) begin
			n_left = left_q - TICK8_W'(1);
			acc    = (n_left == '0);
		end
		n_stable = acc ? n_cand : stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= '0;
			stable_q <= '0;
			left_q   <= '0;
		end else if (en) begin
			cand_q   <= n_cand;
			stable_q <= n_stable;
			left_q   <= n_left;
		end
	end

	// The tick rule sees the levels accepted before this tick.
	assign btn.stable = stable_q;
	assign btn.accept = acc;
	assign btn.level  = n_cand;

endmodule

@@ hdl/smts_core.sv @@
// ----------------------------------------------------------------------------
// smts_core
// Sequencer state and its per-tick update: hold repeat, motion counters,
// page timeout, menu hold and the press actions of accepted buttons.
// ----------------------------------------------------------------------------
`include "screen_and_motor_timed_sequencer_top_defines.svh"

module smts_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  smts_pkg::cfg_t cfg,
	input  smts_pkg::btn_t btn,
	output smts_pkg::res_t res
);
	import smts_pkg::*;

	mode_t               mode_q, n_mode;
	logic [CNT_W-1:0]    mdl_q, sdl_q, mul_q, sul_q;
	logic [CNT_W-1:0]    n_mdl, n_sdl, n_mul, n_sul;
	logic [TICK16_W-1:0] dlead_q, ulead_q, n_dlead, n_ulead;
	logic                dfin_q, ufin_q, n_dfin, n_ufin;
	setting_arr_t        set_q, n_set, saved_set;
	logic [PAGE_W-1:0]   pg_q, n_pg;
	logic [TICK16_W-1:0] pto_q, n_pto;
	logic [TICK16_W-1:0] uhold_q, dhold_q, n_uhold, n_dhold;
	logic [TICK8_W-1:0]  urep_q, drep_q, n_urep, n_drep;
	logic [TICK16_W-1:0] mhc_q, n_mhc;
	logic                md_q, mu_q, sd_q, su_q;
	logic                n_md, n_mu, n_sd, n_su;
	logic                save;
	logic [TICK8_W:0]    rep_nx;
	logic [TICK16_W:0]   mhc_nx;
	logic [NUM_SET-1:0][CNT_W-1:0] prod;

	function automatic setting_arr_t step_setting(input setting_arr_t s,
		input logic [PAGE_W-1:0] pg, input logic up);
		setting_arr_t      r;
		logic [SETTING_W:0] inc;
		logic [1:0]        i;
		r   = s;
		i   = 2'(pg - PAGE_W'(1));
		inc = {1'b0, s[i]} + (SETTING_W+1)'(1);
		if (pg != PAGE_RUN && pg <= PAGE_LAST) begin
			if (up) begin
				r[i] = (inc > {1'b0, SETTING_MAX}) ? '0 : inc[SETTING_W-1:0];
			end else begin
				r[i] = (s[i] == '0) ? SETTING_MAX : s[i] - SETTING_W'(1);
			end
		end
		return r;
	endfunction

	always_comb begin
		n_mode    = mode_q;
		n_mdl     = mdl_q;
		n_sdl     = sdl_q;
		n_mul     = mul_q;
		n_sul     = sul_q;
		n_dlead   = dlead_q;
		n_ulead   = ulead_q;
		n_dfin    = dfin_q;
		n_ufin    = ufin_q;
		n_set     = set_q;
		n_pg      = pg_q;
		n_pto     = pto_q;
		n_uhold   = uhold_q;
		n_dhold   = dhold_q;
		n_urep    = urep_q;
		n_drep    = drep_q;
		n_mhc     = mhc_q;
		n_md      = md_q;
		n_mu      = mu_q;
		n_sd      = sd_q;
		n_su      = su_q;
		save      = 1'b0;
		saved_set = set_q;
		rep_nx    = '0;
		mhc_nx    = '0;

		// Hold auto-repeat, down before up.
		if (btn.stable[1]) begin
			if (n_dhold > TICK16_W'(2)) begin
				n_dhold = n_dhold - TICK16_W'(1);
			end else begin
				n_dhold = TICK16_W'(1);
				rep_nx  = {1'b0, n_drep} + (TICK8_W+1)'(1);
				if (rep_nx > {1'b0, cfg.repeat_period}) begin
					if (n_pg != PAGE_RUN) n_pto = cfg.menu_timeout;
					n_set  = step_setting(n_set, n_pg, 1'b0);
					rep_nx = '0;
				end
				n_drep = rep_nx[TICK8_W-1:0];
			end
		end
		if (btn.stable[0]) begin
			if (n_uhold > TICK16_W'(2)) begin
				n_uhold = n_uhold - TICK16_W'(1);
			end else begin
				n_uhold = TICK16_W'(1);
				rep_nx  = {1'b0, n_urep} + (TICK8_W+1)'(1);
				if (rep_nx > {1'b0, cfg.repeat_period}) begin
					if (n_pg != PAGE_RUN) n_pto = cfg.menu_timeout;
					n_set  = step_setting(n_set, n_pg, 1'b1);
					rep_nx = '0;
				end
				n_urep = rep_nx[TICK8_W-1:0];
			end
		end

		// Motion counters. The drive lines hold their value when not driven.
		case (n_mode)
			MODE_IDLE: begin
				n_md = 1'b0;
				n_mu = 1'b0;
				n_sd = 1'b0;
				n_su = 1'b0;
			end
			MODE_LOWER: begin
				if (n_dlead != '0) begin
					n_dlead = n_dlead - TICK16_W'(1);
				end else if (n_sdl != '0) begin
					n_sd  = 1'b1;
					n_sdl = n_sdl - CNT_W'(1);
				end else begin
					n_sd = 1'b0;
				end
				if (n_mdl != '0) begin
					n_md  = 1'b1;
					n_mdl = n_mdl - CNT_W'(1);
				end else begin
					n_md = 1'b0;
				end
				if (n_sdl == '0 && n_mdl == '0) begin
					n_mode = MODE_IDLE;
					n_dfin = 1'b1;
				end
			end
			MODE_RAISE: begin
				// Raising starts the screen on the tick the lead runs out.
				if (n_ulead != '0) n_ulead = n_ulead - TICK16_W'(1);
				if (n_ulead == '0) begin
					if (n_sul != '0) begin
						n_su  = 1'b1;
						n_sul = n_sul - CNT_W'(1);
					end else begin
						n_su = 1'b0;
					end
				end
				if (n_mul != '0) begin
					n_mu  = 1'b1;
					n_mul = n_mul - CNT_W'(1);
				end else begin
					n_mu = 1'b0;
				end
				if (n_sul == '0 && n_mul == '0) begin
					n_mode = MODE_IDLE;
					n_ufin = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Page timeout.
		if (n_pg != PAGE_RUN) begin
			if (n_pto != '0) n_pto = n_pto - TICK16_W'(1);
			if (n_pto == '0) begin
				save      = 1'b1;
				saved_set = n_set;
				n_pg      = PAGE_RUN;
			end
		end

		// Menu hold aborts motion and advances the page.
		if (btn.stable[2]) begin
			mhc_nx = {1'b0, n_mhc} + (TICK16_W+1)'(1);
			if (mhc_nx > {1'b0, cfg.menu_hold}) begin
				n_mode = MODE_IDLE;
				n_mdl  = '0;
				n_sdl  = '0;
				n_mul  = '0;
				n_sul  = '0;
				n_dfin = 1'b1;
				n_ufin = 1'b1;
				mhc_nx = '0;
				if (n_pg != PAGE_RUN && n_pg <= PAGE_LAST) begin
					save      = 1'b1;
					saved_set = n_set;
				end
				n_pg  = n_pg + PAGE_W'(1);
				n_pto = cfg.menu_timeout;
				if (n_pg > PAGE_LAST) n_pg = PAGE_RUN;
			end
			n_mhc = mhc_nx[TICK16_W-1:0];
		end else begin
			n_mhc = '0;
		end

		// Run counts come from the settings as they stand after the tick rule;
		// the press actions below change settings only off the run page.
		for (int k = 0; k < NUM_SET; k++) begin
			prod[k] = CNT_W'(n_set[k]) * CNT_W'(cfg.ticks_per_unit);
		end

		if (btn.accept) begin
			if (btn.level[0]) begin
				n_uhold = cfg.repeat_delay;
				if (n_pg == PAGE_RUN) begin
					if (n_mode == MODE_IDLE) begin
						n_mdl  = prod[0];
						n_sdl  = prod[1];
						n_mode = MODE_RAISE;
					end
					if (n_mode != MODE_RAISE) begin
						n_mode = MODE_IDLE;
						n_dfin = 1'b1;
					end
					if (n_mode == MODE_RAISE && n_ufin) begin
						n_ufin  = 1'b0;
						n_ulead = cfg.lead_ticks;
						if (n_mul == '0) n_mul = prod[2];
						if (n_sul == '0) n_sul = prod[3];
					end
				end
				if (n_pg != PAGE_RUN) n_pto = cfg.menu_timeout;
				n_set = step_setting(n_set, n_pg, 1'b1);
			end
			if (btn.level[1]) begin
				n_dhold = cfg.repeat_delay;
				if (n_pg == PAGE_RUN) begin
					if (n_mode == MODE_IDLE) begin
						n_mode = MODE_LOWER;
						n_mul  = prod[2];
						n_sul  = prod[3];
					end
					if (n_mode != MODE_LOWER) begin
						n_mode = MODE_IDLE;
						n_ufin = 1'b1;
					end
					if (n_mode == MODE_LOWER && n_dfin) begin
						n_dfin  = 1'b0;
						n_dlead = cfg.lead_ticks;
						if (n_mdl == '0) n_mdl = prod[0];
						if (n_sdl == '0) n_sdl = prod[1];
					end
				end
				if (n_pg != PAGE_RUN) n_pto = cfg.menu_timeout;
				n_set = step_setting(n_set, n_pg, 1'b0);
			end
			if (btn.level[2]) begin
				if (n_pg != PAGE_RUN) n_pto = cfg.menu_timeout;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			mdl_q   <= '0;
			sdl_q   <= '0;
			mul_q   <= '0;
			sul_q   <= '0;
			dlead_q <= '0;
			ulead_q <= '0;
			dfin_q  <= 1'b1;
			ufin_q  <= 1'b1;
			set_q   <= '0;
			pg_q    <= PAGE_RUN;
			pto_q   <= RST_MENU_TIMEOUT;
			uhold_q <= '0;
			dhold_q <= '0;
			urep_q  <= '0;
			drep_q  <= '0;
			mhc_q   <= '0;
			md_q    <= 1'b0;
			mu_q    <= 1'b0;
			sd_q    <= 1'b0;
			su_q    <= 1'b0;
		end else if (en) begin
			mode_q  <= n_mode;
			mdl_q   <= n_mdl;
			sdl_q   <= n_sdl;
			mul_q   <= n_mul;
			sul_q   <= n_sul;
			dlead_q <= n_dlead;
			ulead_q <= n_ulead;
			dfin_q  <= n_dfin;
			ufin_q  <= n_ufin;
			set_q   <= n_set;
			pg_q    <= n_pg;
			pto_q   <= n_pto;
			uhold_q <= n_uhold;
			dhold_q <= n_dhold;
			urep_q  <= n_urep;
			drep_q  <= n_drep;
			mhc_q   <= n_mhc;
			md_q    <= n_md;
			mu_q    <= n_mu;
			sd_q    <= n_sd;
			su_q    <= n_su;
		end
	end

	assign res.motor_down_on  = n_md;
	assign res.motor_up_on    = n_mu;
	assign res.screen_down_on = n_sd;
	assign res.screen_up_on   = n_su;
	assign res.run_mode       = n_mode;
	assign res.page           = n_pg;
	assign res.save_pulse     = save;
	assign res.settings       = save ? saved_set : n_set;

	`SMTS_ASSERT(a_setting_range, clk, arst_n, 1'b1, set_q[0] <= SETTING_MAX && set_q[1] <= SETTING_MAX && set_q[2] <= SETTING_MAX && set_q[3] <= SETTING_MAX)
	`SMTS_ASSERT_NEXT(a_idle_drops_drive, clk, arst_n, en && mode_q == MODE_IDLE, {md_q, mu_q, sd_q, su_q} == 4'b0000)

endmodule

@@ hdl/screen_and_motor_timed_sequencer_top.sv @@
// A tick item passes the input register stage, then the result register
// stage. Throughput: one item per cycle; the whole tick update is one pass
// of logic into the state and result registers. Backpressure on the result
// side stalls the single input register stage. Reset (asynchronous, active
// low): valid, config and state registers return to their defaults, the
// sequencer is idle on the run page and all settings read zero.
// ----------------------------------------------------------------------------
// screen_and_motor_timed_sequencer_top
// Button-driven timed sequencer for a projection screen and its motor.
// ----------------------------------------------------------------------------
`include "screen_and_motor_timed_sequencer_top_defines.svh"

module screen_and_motor_timed_sequencer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [smts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smts_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                up_raw,
	input  logic                                down_raw,
	input  logic                                menu_raw,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                motor_down_on,
	output logic                                motor_up_on,
	output logic                                screen_down_on,
	output logic                                screen_up_on,
	output logic [1:0]                          run_mode,
	output logic [smts_pkg::PAGE_W-1:0]         page,
	output logic                                save_pulse,
	output logic [smts_pkg::SETTING_W-1:0]      motor_down_setting,
	output logic [smts_pkg::SETTING_W-1:0]      screen_down_setting,
	output logic [smts_pkg::SETTING_W-1:0]      motor_up_setting,
	output logic [smts_pkg::SETTING_W-1:0]      screen_up_setting
);
	import smts_pkg::*;

	cfg_t       cfg;
	btn_t       btn;
	res_t       res;
	res_t       res_s2;
	logic       v_s1, v_s2;
	logic [2:0] raw_s1;
	logic       adv;
	logic       en;

	assign adv      = !v_s2 || out_ready;
	assign en       = v_s1 && adv;
	assign in_ready = !v_s1 || adv;

	smts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smts_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.raw            (raw_s1),
		.debounce_ticks (cfg.debounce_ticks),
		.btn            (btn)
	);

	smts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg),
		.btn    (btn),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= {menu_raw, down_raw, up_raw};
		end
		if (en) begin
			res_s2 <= res;
		end
	end

	assign out_valid           = v_s2;
	assign motor_down_on       = res_s2.motor_down_on;
	assign motor_up_on         = res_s2.motor_up_on;
	assign screen_down_on      = res_s2.screen_down_on;
	assign screen_up_on        = res_s2.screen_up_on;
	assign run_mode            = res_s2.run_mode;
	assign page                = res_s2.page;
	assign save_pulse          = res_s2.save_pulse;
	assign motor_down_setting  = res_s2.settings[0];
	assign screen_down_setting = res_s2.settings[1];
	assign motor_up_setting    = res_s2.settings[2];
	assign screen_up_setting   = res_s2.settings[3];

	`SMTS_ASSERT(a_page_range, clk, arst_n, v_s2, res_s2.page <= PAGE_LAST)
	`SMTS_ASSERT(a_mode_legal, clk, arst_n, v_s2, res_s2.run_mode == MODE_IDLE || res_s2.run_mode == MODE_LOWER || res_s2.run_mode == MODE_RAISE)
	`SMTS_ASSERT_NEXT(a_s1_holds, clk, arst_n, v_s1 && !adv, v_s1 && $stable(raw_s1))

endmodule
